// File: rtl/core/xeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_pkg: shared types and tables for the XML entity unescape unit
// Entity prefix nodes, literal characters, the queue entry type and the
// lookup functions for prefix text, depth, transitions and replacements.
// ----------------------------------------------------------------------------
package xeu_pkg;

  localparam int unsigned XEU_CHAR_W = 8;
  localparam int unsigned XEU_QDEPTH = 4;
  localparam int unsigned XEU_QPTR_W = $clog2(XEU_QDEPTH);
  localparam int unsigned XEU_QCNT_W = $clog2(XEU_QDEPTH + 1);
  localparam int unsigned XEU_MAXSTR = 5;
  localparam int unsigned XEU_POS_W  = 3;

  typedef logic [XEU_CHAR_W-1:0] char_t;

  localparam char_t CH_AMP  = 8'h26;  // &
  localparam char_t CH_SEMI = 8'h3B;  // ;
  localparam char_t CH_QUOT = 8'h22;  // "
  localparam char_t CH_APOS = 8'h27;  // '
  localparam char_t CH_LT   = 8'h3C;  // <
  localparam char_t CH_GT   = 8'h3E;  // >
  localparam char_t CH_A    = 8'h61;
  localparam char_t CH_G    = 8'h67;
  localparam char_t CH_L    = 8'h6C;
  localparam char_t CH_M    = 8'h6D;
  localparam char_t CH_O    = 8'h6F;
  localparam char_t CH_P    = 8'h70;
  localparam char_t CH_Q    = 8'h71;
  localparam char_t CH_S    = 8'h73;
  localparam char_t CH_T    = 8'h74;
  localparam char_t CH_U    = 8'h75;
  localparam char_t CH_NUL  = 8'h00;

  // Entity prefix held so far
  typedef enum logic [3:0] {
    N_IDLE  = 4'd0,
    N_AND   = 4'd1,
    N_Q     = 4'd2,
    N_QU    = 4'd3,
    N_QUO   = 4'd4,
    N_QUOT  = 4'd5,
    N_A     = 4'd6,
    N_AP    = 4'd7,
    N_APO   = 4'd8,
    N_APOS  = 4'd9,
    N_AM    = 4'd10,
    N_AMP   = 4'd11,
    N_L     = 4'd12,
    N_LT    = 4'd13,
    N_G     = 4'd14,
    N_GT    = 4'd15
  } node_e;

  typedef logic [XEU_MAXSTR-1:0][XEU_CHAR_W-1:0] str_t;

  // One burst of output: literal text of a prefix node, then an optional byte
  typedef struct packed {
    node_e node;
    logic  has_x;
    char_t x;
    logic  last;
  } desc_t;

  function automatic logic [XEU_POS_W-1:0] node_depth(node_e n);
    logic [XEU_POS_W-1:0] d;
    case (n)
      N_IDLE:                   d = 3'd0;
      N_AND:                    d = 3'd1;
      N_Q, N_A, N_L, N_G:       d = 3'd2;
      N_QU, N_AP, N_AM, N_LT,
      N_GT:                     d = 3'd3;
      N_QUO, N_APO, N_AMP:      d = 3'd4;
      N_QUOT, N_APOS:           d = 3'd5;
      default:                  d = 3'd0;
    endcase
    return d;
  endfunction

  function automatic str_t node_str(node_e n);
    str_t s;
    case (n)
      N_AND:   s = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_AMP};
      N_Q:     s = {CH_NUL, CH_NUL, CH_NUL, CH_Q, CH_AMP};
      N_QU:    s = {CH_NUL, CH_NUL, CH_U, CH_Q, CH_AMP};
      N_QUO:   s = {CH_NUL, CH_O, CH_U, CH_Q, CH_AMP};
      N_QUOT:  s = {CH_T, CH_O, CH_U, CH_Q, CH_AMP};
      N_A:     s = {CH_NUL, CH_NUL, CH_NUL, CH_A, CH_AMP};
      N_AP:    s = {CH_NUL, CH_NUL, CH_P, CH_A, CH_AMP};
      N_APO:   s = {CH_NUL, CH_O, CH_P, CH_A, CH_AMP};
      N_APOS:  s = {CH_S, CH_O, CH_P, CH_A, CH_AMP};
      N_AM:    s = {CH_NUL, CH_NUL, CH_M, CH_A, CH_AMP};
      N_AMP:   s = {CH_NUL, CH_P, CH_M, CH_A, CH_AMP};
      N_L:     s = {CH_NUL, CH_NUL, CH_NUL, CH_L, CH_AMP};
      N_LT:    s = {CH_NUL, CH_NUL, CH_T, CH_L, CH_AMP};
      N_G:     s = {CH_NUL, CH_NUL, CH_NUL, CH_G, CH_AMP};
      N_GT:    s = {CH_NUL, CH_NUL, CH_T, CH_G, CH_AMP};
      default: s = '0;
    endcase
    return s;
  endfunction

  // Child of a prefix node on a byte; idle when there is none
  function automatic node_e node_child(node_e n, char_t c);
    node_e t;
    t = N_IDLE;
    case (n)
      N_AND: begin
        if (c == CH_Q) t = N_Q;
        else if (c == CH_A) t = N_A;
        else if (c == CH_L) t = N_L;
        else if (c == CH_G) t = N_G;
      end
      N_Q:    if (c == CH_U) t = N_QU;
      N_QU:   if (c == CH_O) t = N_QUO;
      N_QUO:  if (c == CH_T) t = N_QUOT;
      N_A: begin
        if (c == CH_P) t = N_AP;
        else if (c == CH_M) t = N_AM;
      end
      N_AP:   if (c == CH_O) t = N_APO;
      N_APO:  if (c == CH_S) t = N_APOS;
      N_AM:   if (c == CH_P) t = N_AMP;
      N_L:    if (c == CH_T) t = N_LT;
      N_G:    if (c == CH_T) t = N_GT;
      default: t = N_IDLE;
    endcase
    return t;
  endfunction

  // Replacement character for a complete name; NUL when incomplete
  function automatic char_t node_result(node_e n);
    char_t r;
    case (n)
      N_QUOT:  r = CH_QUOT;
      N_APOS:  r = CH_APOS;
      N_AMP:   r = CH_AMP;
      N_LT:    r = CH_LT;
      N_GT:    r = CH_GT;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/xeu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_if: request channels of the XML entity unescape unit
// Valid/ready channels for escaped input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface xeu_in_if;
  import xeu_pkg::*;

  logic  valid;
  logic  ready;
  char_t in_char;
  logic  in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface xeu_out_if;
  import xeu_pkg::*;

  logic  valid;
  logic  ready;
  char_t out_char;
  logic  out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// File: rtl/core/xeu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_front: entity prefix tracker
// Accepts input bytes, advances the prefix state and turns each byte into
// one output burst descriptor for the queue, unless it only extends a prefix.
// ----------------------------------------------------------------------------
module xeu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  xeu_in_if.sink         in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output xeu_pkg::desc_t push_desc_o
);
  import xeu_pkg::*;

  node_e state_q, state_d;
  node_e child;
  node_e nstate;
  node_e pnode;
  logic  hx;
  char_t xc;
  char_t res;
  logic  accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  always_comb begin
    child  = node_child(state_q, in_i.in_char);
    res    = node_result(state_q);
    pnode  = N_IDLE;
    hx     = 1'b0;
    xc     = in_i.in_char;
    nstate = state_q;
    if (state_q != N_IDLE && in_i.in_char == CH_SEMI && res != CH_NUL) begin
      hx     = 1'b1;
      xc     = res;
      nstate = N_IDLE;
    end else if (state_q != N_IDLE && child != N_IDLE) begin
      nstate = child;
    end else begin
      pnode = state_q;
      if (in_i.in_char == CH_AMP) begin
        nstate = N_AND;
      end else begin
        hx     = 1'b1;
        nstate = N_IDLE;
      end
    end
    // flush a pending prefix on the final byte
    if (in_i.in_last && nstate != N_IDLE) begin
      if (pnode == N_IDLE) begin
        pnode = nstate;
      end else begin
        hx = 1'b1;
        xc = CH_AMP;
      end
      nstate = N_IDLE;
    end
    state_d = accept ? nstate : state_q;
  end

  assign push_o            = accept && (pnode != N_IDLE || hx);
  assign push_desc_o.node  = pnode;
  assign push_desc_o.has_x = hx;
  assign push_desc_o.x     = xc;
  assign push_desc_o.last  = in_i.in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.in_last) |=> (state_q == N_IDLE))
    else $error("prefix left pending after final byte");
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.in_last) |-> push_o)
    else $error("final byte produced no burst");
  a_push_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (in_i.valid && !q_full_i))
    else $error("burst pushed without an accepted byte");
`endif

endmodule

// File: rtl/core/xeu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_queue: burst descriptor queue
// Short first-in first-out store between the prefix tracker and the emitter.
// ----------------------------------------------------------------------------
module xeu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xeu_pkg::desc_t push_desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output xeu_pkg::desc_t head_o,
  output logic           empty_o
);
  import xeu_pkg::*;

  desc_t                 mem_q [XEU_QDEPTH];
  logic [XEU_QPTR_W-1:0] wr_q, wr_d;
  logic [XEU_QPTR_W-1:0] rd_q, rd_d;
  logic [XEU_QCNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == XEU_QCNT_W'(XEU_QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= XEU_QCNT_W'(XEU_QDEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("pointers disagree on empty queue");
`endif

endmodule

// File: rtl/core/xeu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_back: burst emitter
// Expands the head descriptor into output bytes, one per cycle while the
// receiver is not stalling, into a registered output stage.
// ----------------------------------------------------------------------------
module xeu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  xeu_pkg::desc_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  xeu_out_if.source      out_o
);
  import xeu_pkg::*;

  logic [XEU_POS_W-1:0] pos_q, pos_d;
  logic [XEU_POS_W-1:0] depth;
  logic [XEU_POS_W-1:0] total;
  logic                 load;
  logic                 final_byte;
  str_t                 str;
  char_t                byte_v;
  logic                 valid_q, valid_d;
  char_t                char_q, char_d;
  logic                 last_q, last_d;

  always_comb begin
    depth      = node_depth(head_i.node);
    total      = depth + {{(XEU_POS_W-1){1'b0}}, head_i.has_x};
    str        = node_str(head_i.node);
    final_byte = (pos_q == total - 1'b1);
    byte_v     = (pos_q < depth) ? str[pos_q] : head_i.x;
    load       = !empty_i && (!valid_q || out_o.ready);
    pos_d      = pos_q;
    valid_d    = valid_q && !out_o.ready;
    char_d     = char_q;
    last_d     = last_q;
    if (load) begin
      valid_d = 1'b1;
      char_d  = byte_v;
      last_d  = head_i.last && final_byte;
      pos_d   = final_byte ? '0 : pos_q + 1'b1;
    end
  end

  assign pop_o          = load && final_byte;
  assign out_o.valid    = valid_q;
  assign out_o.out_char = char_q;
  assign out_o.out_last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (pos_q < total))
    else $error("burst position beyond burst length");
  a_pos_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (pos_q == '0))
    else $error("position not rewound after burst");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !final_byte) |=> !last_q)
    else $error("last flag inside a burst");
`endif

endmodule

// File: rtl/core/xml_entity_unescape_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescape_unit: XML predefined entity decoder
// Replaces &quot; &apos; &amp; &lt; &gt; in a byte stream with their
// characters; any other text, broken names included, passes literally.
//
// in_i carries one escaped byte per request, with in_last on the final byte
// of a text. out_o carries decoded bytes, out_last on the final one.
// Input requests are taken one per cycle while the descriptor queue has
// room. Each input byte yields at most one burst of one to six output
// bytes; the emitter hands out one byte per cycle while the receiver is
// not stalling.
// The four-entry descriptor queue and the output register decouple both
// sides: a stalled receiver holds the output register, the queue fills and
// then in_i.ready drops. Reset clears the prefix state, the queue and the
// output valid flag; the block takes input as soon as reset is released.
// ----------------------------------------------------------------------------
module xml_entity_unescape_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  xeu_in_if.sink    in_i,
  xeu_out_if.source out_o
);
  import xeu_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  desc_t push_desc;
  desc_t head;

  xeu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  xeu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty)
  );

  xeu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
